>>> rtl/srt_pkg.sv
// shared types, codes and key helpers for the sorted record table
// no dependencies; imported by every module of the block
package srt_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned KEY_CHARS = 8;

  localparam logic [63:0] KEY_MASK = ~((64'd1 << (64 - 8 * KEY_CHARS)) - 64'd1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_FILTER = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_MISSING = 3'd2,
    ST_FULL    = 3'd3,
    ST_NOMATCH = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SH_RD,
    S_SH_WR,
    S_DEL_RD,
    S_DEL_WR
  } state_e;

  typedef struct packed {
    logic [63:0] key;
    logic [30:0] shares;
    logic [23:0] price;
    logic [2:0]  rating;
  } record_t;

  function automatic logic [63:0] upper_key(input logic [63:0] k);
    logic [63:0] r;
    logic [7:0]  b;
    r = k;
    for (int i = 0; i < 8; i++) begin
      b = k[8*i +: 8];
      if (b >= 8'h61 && b <= 8'h7a) begin
        r[8*i +: 8] = b - 8'h20;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/srt_mem.sv
// record memory: one write port, one read port, registered read data
// depends on srt_pkg for the record type
module srt_mem #(
  parameter int unsigned DEPTH = srt_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  srt_pkg::record_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output srt_pkg::record_t rdata_o
);
  import srt_pkg::*;

  record_t mem [DEPTH];
  record_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/srt_ctrl.sv
// command sequencer: scan, shift up/down, filter hold and output register
// depends on srt_pkg; drives the read and write ports of srt_mem
module srt_ctrl #(
  parameter int unsigned DEPTH = srt_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       command_i,
  input  logic [63:0]      key_in_i,
  input  logic [30:0]      shares_in_i,
  input  logic [23:0]      price_in_i,
  input  logic [23:0]      price_top_i,
  input  logic [2:0]       rating_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       status_o,
  output logic [4:0]       position_o,
  output srt_pkg::record_t out_rec_o,
  output logic             last_o,
  output logic             we_o,
  output logic [AW-1:0]    waddr_o,
  output srt_pkg::record_t wdata_o,
  output logic             re_o,
  output logic [AW-1:0]    raddr_o,
  input  srt_pkg::record_t rdata_i
);
  import srt_pkg::*;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] i_q, i_d;
  logic [AW-1:0] pos_q, pos_d;
  cmd_e          cmd_q, cmd_d;
  logic [63:0]   key_q, key_d;
  logic [30:0]   shares_q, shares_d;
  logic [23:0]   plo_q, plo_d;
  logic [23:0]   phi_q, phi_d;
  logic [2:0]    rat_q, rat_d;
  logic          pend_v_q, pend_v_d;
  record_t       pend_rec_q, pend_rec_d;
  logic [AW-1:0] pend_pos_q, pend_pos_d;

  logic          out_valid_q;
  status_e       out_status_q;
  logic [AW-1:0] out_pos_q;
  record_t       out_rec_q;
  logic          out_last_q;

  logic          push;
  status_e       push_status;
  logic [AW-1:0] push_pos;
  record_t       push_rec;
  logic          push_last;
  logic          can_push;

  logic [63:0]   key_trim;
  logic [CW-1:0] im1, ip1;
  logic          eq, gt, fmatch, full;
  record_t       new_rec;
  logic [AW+4:0] pos_ext;

  assign can_push = !out_valid_q || !out_stall_i;
  assign key_trim = key_in_i & KEY_MASK;
  assign im1      = i_q - 1'b1;
  assign ip1      = i_q + 1'b1;
  assign eq       = rdata_i.key == key_q;
  assign gt       = rdata_i.key > key_q;
  assign fmatch   = rdata_i.rating == rat_q && rdata_i.price >= plo_q &&
                    rdata_i.price <= phi_q;
  assign full     = count_q == CW'(DEPTH);
  assign new_rec  = '{key: key_q, shares: shares_q, price: plo_q, rating: rat_q};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    i_d         = i_q;
    pos_d       = pos_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    shares_d    = shares_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    rat_d       = rat_q;
    pend_v_d    = pend_v_q;
    pend_rec_d  = pend_rec_q;
    pend_pos_d  = pend_pos_q;
    push        = 1'b0;
    push_status = ST_OK;
    push_pos    = '0;
    push_rec    = '0;
    push_last   = 1'b1;
    we_o        = 1'b0;
    waddr_o     = i_q[AW-1:0];
    wdata_o     = rdata_i;
    re_o        = 1'b0;
    raddr_o     = idx_q[AW-1:0];
    in_stall_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_d    = cmd_e'(command_i);
          key_d    = (cmd_e'(command_i) == CMD_INSERT || cmd_e'(command_i) == CMD_DELETE)
                     ? upper_key(key_trim) : key_trim;
          shares_d = shares_in_i;
          plo_d    = price_in_i;
          phi_d    = price_top_i;
          rat_d    = rating_in_i;
          idx_d    = '0;
          pend_v_d = 1'b0;
          state_d  = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx_q == count_q) begin
          // end of scan
          if (can_push) begin
            case (cmd_q)
              CMD_INSERT: begin
                if (full) begin
                  push        = 1'b1;
                  push_status = ST_FULL;
                  state_d     = S_IDLE;
                end else begin
                  pos_d   = idx_q[AW-1:0];
                  i_d     = count_q;
                  state_d = S_SH_RD;
                end
              end
              CMD_FILTER: begin
                push    = 1'b1;
                state_d = S_IDLE;
                if (pend_v_q) begin
                  push_pos = pend_pos_q;
                  push_rec = pend_rec_q;
                end else begin
                  push_status = ST_NOMATCH;
                end
              end
              default: begin
                push        = 1'b1;
                push_status = ST_MISSING;
                state_d     = S_IDLE;
              end
            endcase
          end
        end else begin
          re_o    = 1'b1;
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        case (cmd_q)
          CMD_INSERT: begin
            if (eq) begin
              if (can_push) begin
                push        = 1'b1;
                push_status = ST_DUP;
                push_pos    = idx_q[AW-1:0];
                push_rec    = rdata_i;
                state_d     = S_IDLE;
              end
            end else if (gt) begin
              if (full) begin
                if (can_push) begin
                  push        = 1'b1;
                  push_status = ST_FULL;
                  state_d     = S_IDLE;
                end
              end else begin
                pos_d   = idx_q[AW-1:0];
                i_d     = count_q;
                state_d = S_SH_RD;
              end
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_SCAN_RD;
            end
          end
          CMD_FILTER: begin
            if (fmatch) begin
              // hold the newest match so the final one can carry last
              if (!pend_v_q || can_push) begin
                push       = pend_v_q;
                push_pos   = pend_pos_q;
                push_rec   = pend_rec_q;
                push_last  = 1'b0;
                pend_v_d   = 1'b1;
                pend_rec_d = rdata_i;
                pend_pos_d = idx_q[AW-1:0];
                idx_d      = idx_q + 1'b1;
                state_d    = S_SCAN_RD;
              end
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_SCAN_RD;
            end
          end
          default: begin
            if (eq) begin
              if (can_push) begin
                push     = 1'b1;
                push_pos = idx_q[AW-1:0];
                push_rec = rdata_i;
                i_d      = idx_q;
                state_d  = (cmd_q == CMD_DELETE) ? S_DEL_RD : S_IDLE;
              end
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_SCAN_RD;
            end
          end
        endcase
      end
      S_SH_RD: begin
        if (i_q == CW'(pos_q)) begin
          if (can_push) begin
            we_o     = 1'b1;
            waddr_o  = pos_q;
            wdata_o  = new_rec;
            push     = 1'b1;
            push_pos = pos_q;
            push_rec = new_rec;
            count_d  = count_q + 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          re_o    = 1'b1;
          raddr_o = im1[AW-1:0];
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        we_o    = 1'b1;
        i_d     = im1;
        state_d = S_SH_RD;
      end
      S_DEL_RD: begin
        if (ip1 >= count_q) begin
          count_d = count_q - 1'b1;
          state_d = S_IDLE;
        end else begin
          re_o    = 1'b1;
          raddr_o = ip1[AW-1:0];
          state_d = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        we_o    = 1'b1;
        i_d     = ip1;
        state_d = S_DEL_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_v_q <= pend_v_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    i_q        <= i_d;
    pos_q      <= pos_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    shares_q   <= shares_d;
    plo_q      <= plo_d;
    phi_q      <= phi_d;
    rat_q      <= rat_d;
    pend_rec_q <= pend_rec_d;
    pend_pos_q <= pend_pos_d;
    if (push) begin
      out_status_q <= push_status;
      out_pos_q    <= push_pos;
      out_rec_q    <= push_rec;
      out_last_q   <= push_last;
    end
  end

  assign pos_ext     = {5'd0, out_pos_q};
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign position_o  = pos_ext[4:0];
  assign out_rec_o   = out_rec_q;
  assign last_o      = out_last_q;

endmodule

>>> rtl/sorted_record_table.sv
// top level of the sorted record table: sequencer plus record memory
// depends on srt_pkg, srt_ctrl and srt_mem
//
// Holds up to DEPTH records in ascending key order in one record memory with
// one write port and one registered read port. One command is taken at a
// time; the block stalls its input until the command has finished. Each
// command first scans the stored entries, each visit a memory read, then a
// compare. An insert then moves each larger entry up by one, a delete moves
// each later entry down by one; a filter always scans all entries and emits
// its results as it goes, stalling while the output register is full. No
// clearing pass is needed after reset; entries beyond the fill count are
// never read.
module sorted_record_table #(
  parameter int unsigned DEPTH = srt_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] key_in_i,
  input  logic [30:0] shares_in_i,
  input  logic [23:0] price_in_i,
  input  logic [23:0] price_top_i,
  input  logic [2:0]  rating_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [4:0]  position_o,
  output logic [63:0] key_out_o,
  output logic [30:0] shares_out_o,
  output logic [23:0] price_out_o,
  output logic [2:0]  rating_out_o,
  output logic        last_o
);
  import srt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  record_t       wdata, rdata, out_rec;

  srt_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .key_in_i    (key_in_i),
    .shares_in_i (shares_in_i),
    .price_in_i  (price_in_i),
    .price_top_i (price_top_i),
    .rating_in_i (rating_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .position_o  (position_o),
    .out_rec_o   (out_rec),
    .last_o      (last_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  srt_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign key_out_o    = out_rec.key;
  assign shares_out_o = out_rec.shares;
  assign price_out_o  = out_rec.price;
  assign rating_out_o = out_rec.rating;

endmodule

>>> rtl/srt_checker.sv
// port-level checks for the sorted record table, bound to the top level
// depends on srt_pkg for the status codes
module srt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [4:0]  position_o,
  input logic [63:0] key_out_o,
  input logic        last_o
);
  import srt_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(key_out_o) && $stable(last_o))
    else $error("stalled result changed");

  // one command at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // any error or no-match status is the sole result of its command
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK && status_o != ST_DUP |-> last_o)
    else $error("error status without last");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_MISSING || status_o == ST_FULL ||
    status_o == ST_NOMATCH) |-> position_o == 5'd0 && key_out_o == 64'd0)
    else $error("error result with nonzero fields");

endmodule

bind sorted_record_table srt_checker u_srt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .position_o  (position_o),
  .key_out_o   (key_out_o),
  .last_o      (last_o)
);

>>> bench/testbench.sv
// self-checking bench for the sorted record table: directed table then random commands
// depends on srt_pkg and sorted_record_table; predicts results with a local table model
module testbench;
  import srt_pkg::*;

  localparam int unsigned TBL_DEPTH = 32;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key;
    logic [30:0] shares;
    logic [23:0] price_lo;
    logic [23:0] price_hi;
    logic [2:0]  rating;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  position;
    logic [63:0] key;
    logic [30:0] shares;
    logic [23:0] price;
    logic [2:0]  rating;
    logic        last;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = '0;
  logic [63:0] key_in_i = '0;
  logic [30:0] shares_in_i = '0;
  logic [23:0] price_in_i = '0;
  logic [23:0] price_top_i = '0;
  logic [2:0]  rating_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [4:0]  position_o;
  logic [63:0] key_out_o;
  logic [30:0] shares_out_o;
  logic [23:0] price_out_o;
  logic [2:0]  rating_out_o;
  logic        last_o;

  sorted_record_table DUT (.*);

  always #1 clk_i = ~clk_i;

  // shadow copy of the table
  record_t     shadow_tbl [TBL_DEPTH];
  int unsigned shadow_count;
  reply_t      pending_replies[$];
  int unsigned error_count, item_count, reply_count, filter_hits;
  bit          quiet_phase;
  bit          typed_valid;
  reply_t      typed_reply;

  function automatic logic [63:0] caps(input logic [63:0] k);
    logic [63:0] r;
    r = k;
    for (int i = 0; i < 8; i++)
      if (k[8*i +: 8] >= 8'h61 && k[8*i +: 8] <= 8'h7a) r[8*i +: 8] = k[8*i +: 8] - 8'h20;
    return r;
  endfunction

  function automatic int find_key(input logic [63:0] k);
    int lo, hi, mid;
    lo = 0;
    hi = int'(shadow_count) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_tbl[mid].key == k) return mid;
      if (shadow_tbl[mid].key > k) hi = mid - 1;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  function automatic reply_t entry_reply(input status_e st, input int pos);
    reply_t r;
    r = '0;
    r.status = st;
    r.position = pos[4:0];
    r.key = shadow_tbl[pos].key;
    r.shares = shadow_tbl[pos].shares;
    r.price = shadow_tbl[pos].price;
    r.rating = shadow_tbl[pos].rating;
    return r;
  endfunction

  function automatic reply_t bare_reply(input status_e st);
    reply_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  task automatic queue_reply(input reply_t r);
    pending_replies = {pending_replies, r};
  endtask

  task automatic apply_command(input request_t rq);
    logic [63:0] k;
    int at, i, n0;
    reply_t r;
    k = rq.key & KEY_MASK;
    n0 = pending_replies.size();
    case (cmd_e'(rq.command))
      CMD_INSERT: begin
        k = caps(k);
        at = find_key(k);
        if (at >= 0) queue_reply(entry_reply(ST_DUP, at));
        else if (shadow_count >= TBL_DEPTH) queue_reply(bare_reply(ST_FULL));
        else begin
          i = int'(shadow_count);
          while (i > 0 && k < shadow_tbl[i-1].key) begin
            shadow_tbl[i] = shadow_tbl[i-1];
            i--;
          end
          shadow_tbl[i] = '{key: k, shares: rq.shares, price: rq.price_lo, rating: rq.rating};
          shadow_count++;
          queue_reply(entry_reply(ST_OK, i));
        end
      end
      CMD_DELETE, CMD_LOOKUP: begin
        if (rq.command == CMD_DELETE) k = caps(k);
        at = find_key(k);
        if (at < 0) queue_reply(bare_reply(ST_MISSING));
        else begin
          queue_reply(entry_reply(ST_OK, at));
          if (rq.command == CMD_DELETE) begin
            for (i = at; i + 1 < int'(shadow_count); i++) shadow_tbl[i] = shadow_tbl[i+1];
            shadow_count--;
          end
        end
      end
      default: begin
        for (i = 0; i < int'(shadow_count); i++)
          if (shadow_tbl[i].rating == rq.rating && shadow_tbl[i].price >= rq.price_lo &&
              shadow_tbl[i].price <= rq.price_hi) begin
            queue_reply(entry_reply(ST_OK, i));
            filter_hits++;
          end
        if (pending_replies.size() == n0) queue_reply(bare_reply(ST_NOMATCH));
      end
    endcase
    r = pending_replies[$];
    r.last = 1'b1;
    pending_replies[$] = r;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on reply %0d: %s got %h want %h", reply_count, what, got, want);
    error_count++;
  endtask

  // one request transfer, with random idle cycles before it outside the quiet phase
  task automatic send_request(input request_t rq);
    while (!quiet_phase && $urandom_range(99) < 37) @(posedge clk_i);
    in_valid_i  <= 1'b1;
    command_i   <= rq.command;
    key_in_i    <= rq.key;
    shares_in_i <= rq.shares;
    price_in_i  <= rq.price_lo;
    price_top_i <= rq.price_hi;
    rating_in_i <= rq.rating;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_command(rq);
    item_count++;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected transfer", {61'd0, status_o}, 64'd0);
      end else begin
        want = pending_replies.pop_front();
        if (typed_valid && pending_replies.size() == 0 && typed_reply != want)
          report_mismatch("directed row", 64'({want.status, want.position}),
                          64'({typed_reply.status, typed_reply.position}));
        if (status_o != want.status)
          report_mismatch("status", 64'(status_o), 64'(want.status));
        if (position_o != want.position)
          report_mismatch("position", 64'(position_o), 64'(want.position));
        if (key_out_o != want.key) report_mismatch("key", key_out_o, want.key);
        if (shares_out_o != want.shares)
          report_mismatch("shares", 64'(shares_out_o), 64'(want.shares));
        if (price_out_o != want.price)
          report_mismatch("price", 64'(price_out_o), 64'(want.price));
        if (rating_out_o != want.rating)
          report_mismatch("rating", 64'(rating_out_o), 64'(want.rating));
        if (last_o != want.last) report_mismatch("last", 64'(last_o), 64'(want.last));
      end
      reply_count++;
    end
    out_stall_i <= !quiet_phase && ($urandom_range(99) < 37);
  end

  function automatic logic [63:0] pool_key(input int idx, input bit lower);
    logic [63:0] k;
    k = {8'h41 + 8'(idx % 26), 8'h30 + 8'(idx / 26), 48'd0};
    if (lower) k[63:56] = k[63:56] + 8'h20;
    return k;
  endfunction

  request_t    directed [$];
  logic [3:0]  typed [$];
  request_t    rq;
  int          sel;

  // typed value {known, status} for the final reply of the row
  task automatic add_row(input request_t row, input logic [3:0] tv);
    directed = {directed, row};
    typed    = {typed, tv};
  endtask

  initial begin
    add_row('{CMD_LOOKUP, 64'h4142000000000000, 0, 0, 0, 0}, {1'b1, 3'(ST_MISSING)});
    add_row('{CMD_DELETE, 64'hFFFFFFFFFFFFFFFF, 0, 0, 0, 0}, {1'b1, 3'(ST_MISSING)});
    add_row('{CMD_FILTER, 64'd0, 0, 0, 24'hFFFFFF, 0}, {1'b1, 3'(ST_NOMATCH)});
    add_row('{CMD_INSERT, 64'd0, 31'h7FFFFFFF, 24'hFFFFFF, 0, 7}, 4'd0);
    add_row('{CMD_INSERT, 64'hFFFFFFFFFFFFFFFF, 0, 0, 0, 4}, 4'd0);
    add_row('{CMD_INSERT, 64'h6162637A7B602000, 31'h55555555, 24'hAAAAAA, 0, 0}, 4'd0);
    add_row('{CMD_INSERT, 64'h4142435A7B602000, 1, 2, 0, 3}, 4'd0);
    add_row('{CMD_LOOKUP, 64'h6162637A7B602000, 0, 0, 0, 0}, 4'd0);
    add_row('{CMD_LOOKUP, 64'h4142435A7B602000, 0, 0, 0, 0}, 4'd0);
    add_row('{CMD_FILTER, 64'd0, 0, 24'hFFFFFF, 24'hFFFFFF, 7}, 4'd0);
    add_row('{CMD_FILTER, 64'd0, 0, 24'h000005, 24'h000001, 3}, 4'd0);
    add_row('{CMD_FILTER, 64'd0, 0, 0, 24'hFFFFFF, 3}, 4'd0);
    add_row('{CMD_DELETE, 64'h6162637A7B602000, 0, 0, 0, 0}, 4'd0);
    add_row('{CMD_DELETE, 64'd0, 0, 0, 0, 0}, 4'd0);
    add_row('{CMD_LOOKUP, 64'd0, 0, 0, 0, 0}, {1'b1, 3'(ST_MISSING)});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < directed.size(); i++) begin
      typed_valid = typed[i][3];
      typed_reply = bare_reply(status_e'(typed[i][2:0]));
      typed_reply.last = 1'b1;
      send_request(directed[i]);
      while (pending_replies.size() != 0) @(posedge clk_i);
      typed_valid = 1'b0;
    end

    // clear the table, then random traffic over a small key pool
    for (int i = 0; i < 70; i++) begin
      if (i == 60) begin
        quiet_phase = 1'b1;
        while (pending_replies.size() != 0) @(posedge clk_i);
      end
      if (i == 100) quiet_phase = 1'b0;
    end
    while (shadow_count > 0) begin
      rq = '{CMD_DELETE, shadow_tbl[0].key, 0, 0, 0, 0};
      send_request(rq);
    end

    for (int i = 0; i < 220; i++) begin
      quiet_phase = (i >= 90 && i < 130);
      if (i == 150) while (pending_replies.size() != 0) @(posedge clk_i);
      sel = $urandom_range(99);
      rq.shares   = 31'($urandom());
      rq.price_lo = ($urandom_range(3) == 0) ? 24'($urandom()) : 24'($urandom_range(40));
      rq.price_hi = ($urandom_range(3) == 0) ? 24'($urandom()) : 24'($urandom_range(60));
      rq.rating   = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
      rq.key      = pool_key((i < 120) ? $urandom_range(40) : $urandom_range(8),
                             1'($urandom_range(1)));
      if ($urandom_range(15) == 0) rq.key = {$urandom(), $urandom()};
      if (sel < 45 - (i > 120 ? 25 : 0)) rq.command = CMD_INSERT;
      else if (sel < 65) rq.command = CMD_DELETE;
      else if (sel < 85) rq.command = CMD_LOOKUP;
      else rq.command = CMD_FILTER;
      send_request(rq);
    end

    quiet_phase = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4 * TBL_DEPTH + 10) @(posedge clk_i);
    $display("ran %0d commands, checked %0d replies, %0d filter hits",
             item_count, reply_count, filter_hits);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d replies outstanding", pending_replies.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
rtl/srt_pkg.sv
rtl/srt_mem.sv
rtl/srt_ctrl.sv
rtl/sorted_record_table.sv
rtl/srt_checker.sv
bench/testbench.sv
